/* src/pxu_pkg.sv */
// pxu_pkg: shared types, constants and helper functions of the 2x pixel-art upscaler
// used by every module of the block but pxu_ram; depends on nothing else
package pxu_pkg;

  localparam int IDX_W   = 6;
  localparam int RGB_W   = 24;
  localparam int SUM_W   = 12;
  localparam int TOT_W   = 4;
  localparam int RECIP_W = 16;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W  = 3;

  localparam logic       REQ_PALETTE = 1'b0;
  localparam logic       REQ_PIXEL   = 1'b1;
  localparam logic [7:0] ABSENT_IDX  = 8'hFF;
  localparam logic [3:0] HUE_MAX     = 4'hC;
  localparam logic [3:0] HUE_BLACK   = 4'hF;
  localparam logic [5:0] BLACK_A     = 6'h0D;
  localparam logic [5:0] BLACK_B     = 6'h1D;
  localparam logic [3:0] W_CENTER    = 4'd5;

  // window positions
  localparam int N_WIN  = 9;
  localparam int POS_C  = 0;
  localparam int POS_T  = 1;
  localparam int POS_B  = 2;
  localparam int POS_L  = 3;
  localparam int POS_R  = 4;
  localparam int POS_TL = 5;
  localparam int POS_TR = 6;
  localparam int POS_BL = 7;
  localparam int POS_BR = 8;

  // corner order: upper left, upper right, lower left, lower right
  localparam int N_CORNER = 4;
  localparam int CORNER_V [N_CORNER] = '{POS_T, POS_T, POS_B, POS_B};
  localparam int CORNER_H [N_CORNER] = '{POS_L, POS_R, POS_L, POS_R};
  localparam int CORNER_D [N_CORNER] = '{POS_TL, POS_TR, POS_BL, POS_BR};

  // select bits of one corner
  localparam int SEL_V = 2;
  localparam int SEL_H = 1;
  localparam int SEL_D = 0;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  center_index;
    logic [7:0]  top_index;
    logic [7:0]  bottom_index;
    logic [7:0]  left_index;
    logic [7:0]  right_index;
    logic [7:0]  top_left_index;
    logic [7:0]  top_right_index;
    logic [7:0]  bottom_left_index;
    logic [7:0]  bottom_right_index;
    logic [5:0]  palette_slot;
    logic [23:0] palette_rgb;
  } in_word_t;

  typedef struct packed {
    logic [23:0] upper_left_rgb;
    logic [23:0] upper_right_rgb;
    logic [23:0] lower_left_rgb;
    logic [23:0] lower_right_rgb;
  } out_word_t;

  // classified pixel as it travels from front to back
  typedef struct packed {
    logic                            blank;
    logic [N_CORNER-1:0][2:0]        sel;
    logic [N_WIN-1:0][RGB_W-1:0]     rgb;
  } work_t;

  function automatic logic is_black(input logic [IDX_W-1:0] a);
    logic r;
    r = (a[3:0] == HUE_BLACK) || (a == BLACK_A) || (a == BLACK_B);
    return r;
  endfunction

  function automatic logic is_close(input logic pa, input logic [IDX_W-1:0] a,
                                    input logic pb, input logic [IDX_W-1:0] b);
    logic [1:0] dq;
    logic [3:0] lin;
    logic [3:0] wrap;
    logic [3:0] dp;
    logic [4:0] hq_gap;
    logic       hue_a;
    logic       hue_b;
    logic       r;
    dq    = (a[5:4] > b[5:4]) ? (a[5:4] - b[5:4]) : (b[5:4] - a[5:4]);
    lin   = (a[3:0] > b[3:0]) ? (a[3:0] - b[3:0]) : (b[3:0] - a[3:0]);
    wrap  = HUE_MAX - lin;
    dp    = (lin < wrap) ? lin : wrap;
    hq_gap = {1'b0, dp} + {3'b000, dq};
    hue_a = (a[3:0] != 4'h0) && (a[3:0] <= HUE_MAX);
    hue_b = (b[3:0] != 4'h0) && (b[3:0] <= HUE_MAX);
    r = (a == b) || ((a[3:0] == b[3:0]) && (dq < 2'd3)) ||
        (hue_a && hue_b && (hq_gap < 5'd3)) || (is_black(a) && is_black(b));
    return pa && pb && r;
  endfunction

  // weighted channel sum of one corner
  function automatic logic [SUM_W-1:0] mix_sum(input logic [7:0] c, input logic [7:0] v,
                                               input logic [7:0] h, input logic [7:0] d,
                                               input logic [2:0] sel);
    logic [SUM_W-1:0] s;
    s = {2'b00, c, 2'b00} + {4'h0, c};
    if (sel[SEL_V]) s = s + {3'b000, v, 1'b0};
    if (sel[SEL_H]) s = s + {3'b000, h, 1'b0};
    if (sel[SEL_D]) s = s + {4'h0, d};
    return s;
  endfunction

  function automatic logic [TOT_W-1:0] mix_total(input logic [2:0] sel);
    logic [TOT_W-1:0] t;
    t = W_CENTER + (sel[SEL_V] ? 4'd2 : 4'd0) + (sel[SEL_H] ? 4'd2 : 4'd0) +
        (sel[SEL_D] ? 4'd1 : 4'd0);
    return t;
  endfunction

  // floor(65536 / total), totals run from 5 to 10
  function automatic logic [RECIP_W-1:0] recip(input logic [TOT_W-1:0] t);
    logic [RECIP_W-1:0] m;
    unique case (t)
      4'd5:    m = 16'd13107;
      4'd6:    m = 16'd10922;
      4'd7:    m = 16'd9362;
      4'd8:    m = 16'd8192;
      4'd9:    m = 16'd7281;
      4'd10:   m = 16'd6553;
      default: m = 16'd13107;
    endcase
    return m;
  endfunction

endpackage

/* src/pxu_ram.sv */
// pxu_ram: generic single write port, single read port ram with registered read
// depends on nothing else
module pxu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/pxu_front.sv */
// pxu_front: accepts words, writes the palette, classifies pixel windows and reads colors
// depends on pxu_pkg and pxu_ram
module pxu_front #(
  parameter int PALETTE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  pxu_pkg::in_word_t in_data,
  output logic              push_valid,
  output pxu_pkg::work_t    push_data
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic [pxu_pkg::N_WIN-1:0][7:0]              raw;
  logic [pxu_pkg::N_WIN-1:0]                   pres;
  logic [pxu_pkg::N_WIN-1:0][pxu_pkg::IDX_W-1:0] idx;
  logic [pxu_pkg::N_WIN-1:0][AW-1:0]           addr;
  logic [pxu_pkg::N_WIN-1:0]                   ok;
  logic [pxu_pkg::N_WIN-1:0][pxu_pkg::RGB_W-1:0] rdata;
  logic [pxu_pkg::N_CORNER-1:0][2:0]           sel;
  logic [PALETTE_ENTRIES-1:0]                  ent_valid_r;
  logic [PALETTE_ENTRIES-1:0]                  ent_valid_nxt;
  logic                                        pal_we;
  logic [AW-1:0]                               pal_addr;
  logic                                        front_valid_r;
  logic                                        blank_r;
  logic [pxu_pkg::N_WIN-1:0]                   ok_r;
  logic [pxu_pkg::N_CORNER-1:0][2:0]           sel_r;

  // window in fixed positions
  assign raw[pxu_pkg::POS_C]  = in_data.center_index;
  assign raw[pxu_pkg::POS_T]  = in_data.top_index;
  assign raw[pxu_pkg::POS_B]  = in_data.bottom_index;
  assign raw[pxu_pkg::POS_L]  = in_data.left_index;
  assign raw[pxu_pkg::POS_R]  = in_data.right_index;
  assign raw[pxu_pkg::POS_TL] = in_data.top_left_index;
  assign raw[pxu_pkg::POS_TR] = in_data.top_right_index;
  assign raw[pxu_pkg::POS_BL] = in_data.bottom_left_index;
  assign raw[pxu_pkg::POS_BR] = in_data.bottom_right_index;

  // normalize indices and check the palette entry behind each
  always_comb begin
    for (int k = 0; k < pxu_pkg::N_WIN; k++) begin
      pres[k] = (raw[k] != pxu_pkg::ABSENT_IDX);
      idx[k]  = raw[k][pxu_pkg::IDX_W-1:0];
      addr[k] = AW'(idx[k]);
      ok[k]   = pres[k] && (32'(idx[k]) < PALETTE_ENTRIES) && ent_valid_r[addr[k]];
    end
  end

  // pick contributing neighbours of each corner
  always_comb begin
    logic cv, ch, cd, any;
    for (int k = 0; k < pxu_pkg::N_CORNER; k++) begin
      cv  = pxu_pkg::is_close(pres[pxu_pkg::POS_C], idx[pxu_pkg::POS_C],
                              pres[pxu_pkg::CORNER_V[k]], idx[pxu_pkg::CORNER_V[k]]);
      ch  = pxu_pkg::is_close(pres[pxu_pkg::POS_C], idx[pxu_pkg::POS_C],
                              pres[pxu_pkg::CORNER_H[k]], idx[pxu_pkg::CORNER_H[k]]);
      cd  = pxu_pkg::is_close(pres[pxu_pkg::POS_C], idx[pxu_pkg::POS_C],
                              pres[pxu_pkg::CORNER_D[k]], idx[pxu_pkg::CORNER_D[k]]);
      any = cv || ch || cd;
      sel[k][pxu_pkg::SEL_V] = any ? cv : pres[pxu_pkg::CORNER_V[k]];
      sel[k][pxu_pkg::SEL_H] = any ? ch : pres[pxu_pkg::CORNER_H[k]];
      sel[k][pxu_pkg::SEL_D] = any ? cd : pres[pxu_pkg::CORNER_D[k]];
    end
  end

  // palette write
  assign pal_addr = AW'(in_data.palette_slot);
  assign pal_we   = in_fire && (in_data.req_type == pxu_pkg::REQ_PALETTE) &&
                    (32'(in_data.palette_slot) < PALETTE_ENTRIES);

  always_comb begin
    ent_valid_nxt = ent_valid_r;
    if (pal_we) begin
      ent_valid_nxt[pal_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
    end else begin
      ent_valid_r <= ent_valid_nxt;
    end
  end

  // one palette copy per window position
  for (genvar g = 0; g < pxu_pkg::N_WIN; g++) begin : g_pal
    pxu_ram #(
      .WIDTH (pxu_pkg::RGB_W),
      .DEPTH (PALETTE_ENTRIES)
    ) u_ram (
      .clk   (clk),
      .we    (pal_we),
      .waddr (pal_addr),
      .wdata (in_data.palette_rgb),
      .raddr (addr[g]),
      .rdata (rdata[g])
    );
  end

  // classification register, aligned with the ram read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= in_fire && (in_data.req_type == pxu_pkg::REQ_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      blank_r <= !pres[pxu_pkg::POS_C];
      ok_r    <= ok;
      sel_r   <= sel;
    end
  end

  // work word toward the queue
  always_comb begin
    push_data.blank = blank_r;
    push_data.sel   = sel_r;
    for (int k = 0; k < pxu_pkg::N_WIN; k++) begin
      push_data.rgb[k] = ok_r[k] ? rdata[k] : '0;
    end
  end

  assign push_valid = front_valid_r;

endmodule

/* src/pxu_queue.sv */
// pxu_queue: short fifo of classified words between front and back
// depends on pxu_pkg
module pxu_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  pxu_pkg::work_t                push_data,
  input  logic                          pop,
  output pxu_pkg::work_t                head,
  output logic                          not_empty,
  output logic [pxu_pkg::QCNT_W-1:0]    count
);

  localparam int PW = $clog2(pxu_pkg::QUEUE_DEPTH);

  pxu_pkg::work_t               slots [pxu_pkg::QUEUE_DEPTH];
  logic [PW-1:0]                wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]                rd_ptr_r, rd_ptr_nxt;
  logic [pxu_pkg::QCNT_W-1:0]   count_r, count_nxt;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

  assign head      = slots[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

/* src/pxu_back.sv */
// pxu_back: weighted color mix and divide by total weight, with output register
// depends on pxu_pkg
module pxu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  pxu_pkg::work_t     head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output pxu_pkg::out_word_t out_data
);

  localparam int NCH = 3;

  logic                                           adv;
  logic                                           s1_valid_r, s2_valid_r, out_valid_r;
  logic [pxu_pkg::N_CORNER-1:0][NCH-1:0][pxu_pkg::SUM_W-1:0]  sum_nxt, s1_sum_r, s2_sum_r;
  logic [pxu_pkg::N_CORNER-1:0][pxu_pkg::TOT_W-1:0]           tot_nxt, s1_tot_r, s2_tot_r;
  logic [pxu_pkg::N_CORNER-1:0][NCH-1:0][pxu_pkg::PROD_W-1:0] prod_nxt, s2_prod_r;
  logic [pxu_pkg::N_CORNER-1:0][NCH-1:0][7:0]                 q_nxt;
  logic [pxu_pkg::N_CORNER-1:0][pxu_pkg::RGB_W-1:0]           rgb_nxt, out_rgb_r;

  // whole back pipeline moves unless the result is held
  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && head_valid;

  // stage 1: weighted sums
  always_comb begin
    logic [7:0] c, v, h, d;
    for (int k = 0; k < pxu_pkg::N_CORNER; k++) begin
      tot_nxt[k] = pxu_pkg::mix_total(head.sel[k]);
      for (int ch = 0; ch < NCH; ch++) begin
        c = head.rgb[pxu_pkg::POS_C][ch*8 +: 8];
        v = head.rgb[pxu_pkg::CORNER_V[k]][ch*8 +: 8];
        h = head.rgb[pxu_pkg::CORNER_H[k]][ch*8 +: 8];
        d = head.rgb[pxu_pkg::CORNER_D[k]][ch*8 +: 8];
        sum_nxt[k][ch] = head.blank ? '0 : pxu_pkg::mix_sum(c, v, h, d, head.sel[k]);
      end
    end
  end

  // stage 2: multiply by reciprocal of the total
  always_comb begin
    for (int k = 0; k < pxu_pkg::N_CORNER; k++) begin
      for (int ch = 0; ch < NCH; ch++) begin
        prod_nxt[k][ch] = pxu_pkg::PROD_W'(s1_sum_r[k][ch]) *
                          pxu_pkg::PROD_W'(pxu_pkg::recip(s1_tot_r[k]));
      end
    end
  end

  // stage 3: estimate is low by at most one, fix with the remainder
  always_comb begin
    logic [pxu_pkg::SUM_W-1:0] qe, rem;
    for (int k = 0; k < pxu_pkg::N_CORNER; k++) begin
      for (int ch = 0; ch < NCH; ch++) begin
        qe  = s2_prod_r[k][ch][pxu_pkg::PROD_W-1 -: pxu_pkg::SUM_W];
        rem = s2_sum_r[k][ch] - pxu_pkg::SUM_W'(qe * pxu_pkg::SUM_W'(s2_tot_r[k]));
        q_nxt[k][ch] = (rem >= pxu_pkg::SUM_W'(s2_tot_r[k])) ? 8'(qe + 1'b1) : qe[7:0];
      end
      rgb_nxt[k] = {q_nxt[k][2], q_nxt[k][1], q_nxt[k][0]};
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= head_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sum_r  <= sum_nxt;
      s1_tot_r  <= tot_nxt;
      s2_sum_r  <= s1_sum_r;
      s2_tot_r  <= s1_tot_r;
      s2_prod_r <= prod_nxt;
      out_rgb_r <= rgb_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_data.upper_left_rgb  = out_rgb_r[0];
  assign out_data.upper_right_rgb = out_rgb_r[1];
  assign out_data.lower_left_rgb  = out_rgb_r[2];
  assign out_data.lower_right_rgb = out_rgb_r[3];

endmodule

/* src/pixel_art_2x_upscaler_unit.sv */
// pixel_art_2x_upscaler_unit: top level of the 2x pixel-art upscaler
// depends on pxu_pkg, pxu_front, pxu_queue, pxu_back
//
// usage
//   input channel in_valid / in_stall / in_data carries palette writes and pixel
//   windows. a palette write word updates one palette entry and gives no result.
//   a pixel word gives one result word on out_valid / out_stall / out_data with
//   the four sub-pixel colors of the 2x block.
//   a pixel passes the front register, the queue, the sum stage, the multiply
//   stage and the output register before its result shows.
//   throughput: one word per cycle while in_stall is low. the front reads nine
//   palette copies in parallel, one per window position, so no word waits there.
//   a palette write is visible to the very next pixel word.
//   reset: palette reads black until an entry is written; a per-entry valid bit
//   does this, there is no clearing pass, words are taken right after reset.
//   stall: the back holds its pipeline while out_stall holds a result; the front
//   keeps accepting until the queue words plus the word in the front register
//   take all four queue slots, then raises in_stall.
module pixel_art_2x_upscaler_unit #(
  parameter int PALETTE_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pxu_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pxu_pkg::out_word_t out_data
);

  logic                       in_fire;
  logic                       push_valid;
  pxu_pkg::work_t             push_data;
  logic                       pop;
  pxu_pkg::work_t             head;
  logic                       not_empty;
  logic [pxu_pkg::QCNT_W-1:0] count;
  logic [pxu_pkg::QCNT_W:0]   pending;

  // reserve a queue slot for every word in flight in the front
  assign pending  = {1'b0, count} + {{pxu_pkg::QCNT_W{1'b0}}, push_valid};
  assign in_stall = (pending >= (pxu_pkg::QCNT_W+1)'(pxu_pkg::QUEUE_DEPTH));
  assign in_fire  = in_valid && !in_stall;

  pxu_front #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  pxu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .count     (count)
  );

  pxu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (not_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

/* src/pxu_checker.sv */
// pxu_checker: port level checks of the upscaler, bound to the top level
// depends on pxu_pkg and pixel_art_2x_upscaler_unit
module pxu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input pxu_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input pxu_pkg::out_word_t out_data
);

  logic       pix_in;
  logic       word_out;
  logic [3:0] pend_r, pend_nxt;

  // pixel words accepted but not yet delivered
  assign pix_in   = in_valid && !in_stall && (in_data.req_type == pxu_pkg::REQ_PIXEL);
  assign word_out = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r;
    if (pix_in && !word_out) begin
      pend_nxt = pend_r + 1'b1;
    end else if (word_out && !pix_in) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_no_out_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word right after reset");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result word without a pending pixel");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'd8)
    else $error("more pixels in flight than the block can hold");

endmodule

bind pixel_art_2x_upscaler_unit pxu_checker u_chk (.*);
